/* rtl/core/i2r_pkg.sv */
// Shared constants, types and the microcode table of the integer-to-radix-digits converter.
package i2r_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned RADIX_W        = 5;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned DIV_STEP       = 8;   // dividend bits retired per divide cycle
  localparam int unsigned STEP_W         = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 8'h2D;

  // Sequencer step addresses.
  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_RADIX    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SIGNCHK  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SIGN     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DIVINIT  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DIV      = 4'd5;
  localparam logic [STEP_W-1:0] STEP_PUSH     = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RDSET    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RDWAIT   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd9;
  localparam logic [STEP_W-1:0] STEP_NEXT     = 4'd10;
  localparam logic [STEP_W-1:0] STEP_NEXTWAIT = 4'd11;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_RADIX_BAD,
    COND_NOT_NEG,
    COND_OUT_FULL,
    COND_DIV_MORE,
    COND_MORE_DIGITS,
    COND_RP_ZERO
  } cond_e;

  // Datapath actions for one cycle.
  typedef struct packed {
    logic ld;
    logic emit_sign;
    logic div_start;
    logic div_step;
    logic push;
    logic rd_start;
    logic emit_digit;
    logic dec_rp;
  } ctrl_t;

  // Datapath status seen by the jump conditions.
  typedef struct packed {
    logic in_valid;
    logic radix_bad;
    logic neg;
    logic out_full;
    logic div_more;
    logic more_digits;
    logic rp_zero;
  } stat_t;

  // One control word: jump condition and target, whether the actions are
  // suppressed when the jump is taken, and the actions themselves.
  typedef struct packed {
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              gate;
    ctrl_t             act;
  } ucode_t;

  function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.cond = COND_NO_INPUT; w.target = STEP_IDLE; w.gate = 1'b1; w.act.ld = 1'b1;
      end
      STEP_RADIX: begin
        w.cond = COND_RADIX_BAD; w.target = STEP_IDLE;
      end
      STEP_SIGNCHK: begin
        w.cond = COND_NOT_NEG; w.target = STEP_DIVINIT;
      end
      STEP_SIGN: begin
        w.cond = COND_OUT_FULL; w.target = STEP_SIGN; w.gate = 1'b1;
        w.act.emit_sign = 1'b1;
      end
      STEP_DIVINIT: begin
        w.cond = COND_NEVER; w.target = STEP_IDLE; w.act.div_start = 1'b1;
      end
      STEP_DIV: begin
        w.cond = COND_DIV_MORE; w.target = STEP_DIV; w.act.div_step = 1'b1;
      end
      STEP_PUSH: begin
        w.cond = COND_MORE_DIGITS; w.target = STEP_DIV;
        w.act.push = 1'b1; w.act.div_start = 1'b1;
      end
      STEP_RDSET: begin
        w.cond = COND_NEVER; w.target = STEP_IDLE; w.act.rd_start = 1'b1;
      end
      STEP_RDWAIT: begin
        w.cond = COND_NEVER; w.target = STEP_IDLE;
      end
      STEP_EMIT: begin
        w.cond = COND_OUT_FULL; w.target = STEP_EMIT; w.gate = 1'b1;
        w.act.emit_digit = 1'b1;
      end
      STEP_NEXT: begin
        w.cond = COND_RP_ZERO; w.target = STEP_IDLE; w.gate = 1'b1; w.act.dec_rp = 1'b1;
      end
      STEP_NEXTWAIT: begin
        w.cond = COND_ALWAYS; w.target = STEP_EMIT;
      end
      default: begin
        w.cond = COND_ALWAYS; w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = 8'h37 + {4'd0, d};
    end
    return c;
  endfunction

endpackage

/* rtl/core/integer_to_radix_digits.sv */
// Top level of the signed integer to radix text converter.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        tdata[VALUE_BITS-1:0] = value
//  m_axis    out        m_axis_tvalid/tready        tdata[7:0] = character, tlast = last
//  cfg       in         cfg_we_i                    cfg_wdata_i[4:0] = radix
//
// One item at a time, taken only while idle. After an optional minus sign, each digit
// comes from divide steps that each retire eight dividend bits, followed by a push; the
// digits are then read back through the digit memory's registered read and emitted via
// the emit, next and next-wait steps, the final character skipping the next-wait step.
// An out-of-range radix drops the item at the radix check step, before any output.
// Reset clears the step counter and output valid, radix ten; stalls hold the emit steps.
module integer_to_radix_digits #(
  parameter int unsigned VALUE_BITS = i2r_pkg::VALUE_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // value
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0]  s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // character
  output logic [i2r_pkg::CHAR_W-1:0]               m_axis_tdata,
  output logic                                     m_axis_tlast,
  input  logic                                     cfg_we_i,
  input  logic [i2r_pkg::RADIX_W-1:0]              cfg_wdata_i
);

  i2r_pkg::ctrl_t ctrl;
  i2r_pkg::stat_t stat;
  logic           idle;

  i2r_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .idle_o (idle)
  );

  i2r_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (s_axis_tvalid),
    .value_i     (s_axis_tdata[VALUE_BITS-1:0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = idle;

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sequencer stayed idle after taking an item");

  a_emit_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit_sign || ctrl.emit_digit) |-> !stat.out_full)
    else $error("character written over a stalled output");

  a_one_action : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.ld, ctrl.emit_sign, ctrl.emit_digit, ctrl.div_step, ctrl.push}))
    else $error("conflicting datapath actions");

  a_sign_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata == i2r_pkg::CHAR_MINUS)) |-> !m_axis_tlast)
    else $error("minus sign marked as final character");
`endif

endmodule

/* rtl/core/i2r_sequencer.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module i2r_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2r_pkg::stat_t      stat_i,
  output i2r_pkg::ctrl_t      ctrl_o,
  output logic                idle_o
);

  logic [i2r_pkg::STEP_W-1:0] pc_q, pc_d;
  i2r_pkg::ucode_t            uw;
  logic                       take;

  assign uw = i2r_pkg::ucode_word(pc_q);

  always_comb begin
    unique case (uw.cond)
      i2r_pkg::COND_NEVER:       take = 1'b0;
      i2r_pkg::COND_ALWAYS:      take = 1'b1;
      i2r_pkg::COND_NO_INPUT:    take = !stat_i.in_valid;
      i2r_pkg::COND_RADIX_BAD:   take = stat_i.radix_bad;
      i2r_pkg::COND_NOT_NEG:     take = !stat_i.neg;
      i2r_pkg::COND_OUT_FULL:    take = stat_i.out_full;
      i2r_pkg::COND_DIV_MORE:    take = stat_i.div_more;
      i2r_pkg::COND_MORE_DIGITS: take = stat_i.more_digits;
      i2r_pkg::COND_RP_ZERO:     take = stat_i.rp_zero;
      default:                   take = 1'b1;
    endcase
  end

  assign pc_d   = take ? uw.target : pc_q + 1'b1;
  assign ctrl_o = (uw.gate && take) ? '0 : uw.act;
  assign idle_o = (pc_q == i2r_pkg::STEP_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= i2r_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/core/i2r_datapath.sv */
// Datapath: radix register, magnitude divider, digit memory and output register.
module i2r_datapath #(
  parameter int unsigned VALUE_BITS = i2r_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  i2r_pkg::ctrl_t                ctrl_i,
  output i2r_pkg::stat_t                stat_o,
  input  logic                          in_valid_i,
  input  logic [VALUE_BITS-1:0]         value_i,
  input  logic                          cfg_we_i,
  input  logic [i2r_pkg::RADIX_W-1:0]   cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [i2r_pkg::CHAR_W-1:0]    out_char_o,
  output logic                          out_last_o
);

  localparam int unsigned NDIV  = (VALUE_BITS + i2r_pkg::DIV_STEP - 1) / i2r_pkg::DIV_STEP;
  localparam int unsigned DIV_W = NDIV * i2r_pkg::DIV_STEP;
  localparam int unsigned CNT_W = (NDIV > 1) ? $clog2(NDIV) : 1;
  localparam int unsigned AW    = $clog2(VALUE_BITS);
  localparam int unsigned ND_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned DW    = i2r_pkg::DIGIT_W;

  logic [i2r_pkg::RADIX_W-1:0]   radix_q;
  logic                          neg_q;
  logic [DIV_W-1:0]              dq_q;
  logic [DW-1:0]                 r_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [ND_W-1:0]               nd_q;
  logic [AW-1:0]                 rp_q;
  logic [DW-1:0]                 rd_q;
  logic [DW-1:0]                 mem [VALUE_BITS];
  logic                          out_valid_q;
  logic [i2r_pkg::CHAR_W-1:0]    out_char_q;
  logic                          out_last_q;

  logic [VALUE_BITS-1:0]         mag;
  logic [i2r_pkg::RADIX_W-1:0]   rem;
  logic [i2r_pkg::DIV_STEP-1:0]  qbits;
  logic                          out_full;

  assign mag = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;

  // Restoring division of the top byte of the dividend; the remainder stays
  // below the radix, so it fits in four bits between cycles.
  always_comb begin
    rem   = {1'b0, r_q};
    qbits = '0;
    for (int j = 0; j < int'(i2r_pkg::DIV_STEP); j++) begin
      rem = {rem[DW-1:0], dq_q[DIV_W-1-j]};
      if (rem >= radix_q) begin
        rem = rem - radix_q;
        qbits[i2r_pkg::DIV_STEP-1-j] = 1'b1;
      end
    end
  end

  assign out_full = out_valid_q && !out_ready_i;

  assign stat_o.in_valid    = in_valid_i;
  assign stat_o.radix_bad   = (radix_q < i2r_pkg::RADIX_MIN) || (radix_q > i2r_pkg::RADIX_MAX);
  assign stat_o.neg         = neg_q;
  assign stat_o.out_full    = out_full;
  assign stat_o.div_more    = (cnt_q != CNT_W'(NDIV - 1));
  assign stat_o.more_digits = (dq_q != '0) &&
                              (({1'b0, nd_q} + 1'b1) < (ND_W + 1)'(VALUE_BITS));
  assign stat_o.rp_zero     = (rp_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= i2r_pkg::RADIX_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (ctrl_i.emit_sign || ctrl_i.emit_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld) begin
      neg_q <= value_i[VALUE_BITS-1];
      dq_q  <= DIV_W'(mag);
      nd_q  <= '0;
    end else if (ctrl_i.div_step) begin
      dq_q <= (dq_q << i2r_pkg::DIV_STEP) | DIV_W'(qbits);
    end
    if (ctrl_i.div_start) begin
      r_q   <= '0;
      cnt_q <= '0;
    end else if (ctrl_i.div_step) begin
      r_q   <= rem[DW-1:0];
      cnt_q <= cnt_q + 1'b1;
    end
    if (ctrl_i.push) begin
      nd_q <= nd_q + 1'b1;
    end
    if (ctrl_i.rd_start) begin
      rp_q <= AW'(nd_q - 1'b1);
    end else if (ctrl_i.dec_rp) begin
      rp_q <= rp_q - 1'b1;
    end
    if (ctrl_i.emit_sign) begin
      out_char_q <= i2r_pkg::CHAR_MINUS;
      out_last_q <= 1'b0;
    end else if (ctrl_i.emit_digit) begin
      out_char_q <= i2r_pkg::digit_char(rd_q);
      out_last_q <= (rp_q == '0);
    end
  end

  // Digit store: written least significant digit first, read back in reverse.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[nd_q[AW-1:0]] <= r_q;
    end
    rd_q <= mem[rp_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule
